### sv/clpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_pkg
// Widths, register map, codes, stage records and the clamp helper shared by
// the clamped PID controller.
// ----------------------------------------------------------------------------
package clpid_pkg;

  // Sample and gain formats
  localparam int SAMPLE_BITS    = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int DRIVE_W        = 16;
  localparam int SUM_W          = 32;

  // Register field widths
  localparam int OUT_LIM_W  = 15;
  localparam int ERR_LIM_W  = 17;
  localparam int DIFF_LIM_W = 18;
  localparam int INT_LIM_W  = 31;
  localparam int BAND_W     = 17;

  // Error path widths: a difference of two samples, and of two errors
  localparam int ERR_W  = SAMPLE_BITS + 1;
  localparam int DIFF_W = ERR_W + 1;
  localparam int MAG_W  = (ERR_W > BAND_W) ? ERR_W : BAND_W;

  // Product and accumulator widths
  localparam int P_W   = GAIN_W + ERR_W;
  localparam int I_W   = GAIN_W + SUM_W;
  localparam int D_W   = GAIN_W + DIFF_W;
  localparam int PROD_MAX_W = (I_W > D_W) ? I_W : D_W;
  localparam int ACC_W = PROD_MAX_W + 2;

  // Clamp helper works on the widest value it ever sees
  localparam int CLAMP_W = ACC_W;
  localparam int LIM_W   = 32;

  localparam int DRIVE_MAX = 2 ** (DRIVE_W - 1) - 1;
  localparam int DRIVE_MIN = -(2 ** (DRIVE_W - 1));

  // APB register port
  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  typedef enum logic [2:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_OUTPUT_LIMIT   = 3'd3,
    REG_ERROR_LIMIT    = 3'd4,
    REG_DIFF_LIMIT     = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_ACCURACY_BAND  = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_START  = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [OUT_LIM_W-1:0]     output_limit;
    logic [ERR_LIM_W-1:0]     error_limit;
    logic [DIFF_LIM_W-1:0]    diff_limit;
    logic [INT_LIM_W-1:0]     integral_limit;
    logic [BAND_W-1:0]        accuracy_band;
  } cfg_t;

  // Error stage record
  typedef struct packed {
    logic                     valid;
    logic                     start;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
    logic                     done;
  } err_stage_t;

  // Product stage record
  typedef struct packed {
    logic                  valid;
    logic                  start;
    logic signed [P_W-1:0] p_term;
    logic signed [I_W-1:0] i_term;
    logic signed [D_W-1:0] d_term;
    logic                  done;
  } prod_stage_t;

  // Magnitude clamp; a zero limit leaves the value alone
  function automatic logic signed [CLAMP_W-1:0] clamp_abs(
    input logic signed [CLAMP_W-1:0] v,
    input logic [LIM_W-1:0]          lim
  );
    logic signed [CLAMP_W-1:0] l;
    logic signed [CLAMP_W-1:0] r;
    l = $signed({{(CLAMP_W - LIM_W){1'b0}}, lim});
    r = v;
    if (lim != '0) begin
      if (v > 0) begin
        r = (v > l) ? l : v;
      end else begin
        r = (v < -l) ? -l : v;
      end
    end
    return r;
  endfunction

endpackage

### sv/clpid_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_in_if
// Input channel: operation, sensor sample and target, with valid/ready.
// ----------------------------------------------------------------------------
interface clpid_in_if;
  import clpid_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] sensor_value;
  logic signed [SAMPLE_BITS-1:0] target_value;

  modport source (output valid, output operation, output sensor_value,
                  output target_value, input ready);
  modport sink   (input valid, input operation, input sensor_value,
                  input target_value, output ready);
endinterface

### sv/clpid_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_out_if
// Result channel: drive command and done flag, with valid/ready.
// ----------------------------------------------------------------------------
interface clpid_out_if;
  import clpid_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      done_res;

  modport source (output valid, output drive, output done_res, input ready);
  modport sink   (input valid, input drive, input done_res, output ready);
endinterface

### sv/clpid_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_regs
// APB register file holding gains, limits and the accuracy band.
// ----------------------------------------------------------------------------
module clpid_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clpid_pkg::APB_AW-1:0] paddr,
  input  logic [clpid_pkg::APB_DW-1:0] pwdata,
  output logic [clpid_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output clpid_pkg::cfg_t             cfg_o
);
  import clpid_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:      cfg_d.prop_gain      = pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg_d.integ_gain     = pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg_d.deriv_gain     = pwdata[GAIN_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_d.output_limit   = pwdata[OUT_LIM_W-1:0];
        REG_ERROR_LIMIT:    cfg_d.error_limit    = pwdata[ERR_LIM_W-1:0];
        REG_DIFF_LIMIT:     cfg_d.diff_limit     = pwdata[DIFF_LIM_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_d.integral_limit = pwdata[INT_LIM_W-1:0];
        REG_ACCURACY_BAND:  cfg_d.accuracy_band  = pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Read decode, fields zero-extended
  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:      prdata = APB_DW'(unsigned'(cfg_q.prop_gain));
      REG_INTEG_GAIN:     prdata = APB_DW'(unsigned'(cfg_q.integ_gain));
      REG_DERIV_GAIN:     prdata = APB_DW'(unsigned'(cfg_q.deriv_gain));
      REG_OUTPUT_LIMIT:   prdata = APB_DW'(cfg_q.output_limit);
      REG_ERROR_LIMIT:    prdata = APB_DW'(cfg_q.error_limit);
      REG_DIFF_LIMIT:     prdata = APB_DW'(cfg_q.diff_limit);
      REG_INTEGRAL_LIMIT: prdata = APB_DW'(cfg_q.integral_limit);
      REG_ACCURACY_BAND:  prdata = APB_DW'(cfg_q.accuracy_band);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/clpid_err_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_err_path
// Input register, controller state, and the error / difference / sum stage.
// ----------------------------------------------------------------------------
module clpid_err_path (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  clpid_in_if.sink              in_ch,
  input  clpid_pkg::cfg_t       cfg_i,
  input  logic                  ready_i,
  output clpid_pkg::err_stage_t stage_o
);
  import clpid_pkg::*;

  // Input register
  logic                          in_valid_q;
  logic                          in_op_q;
  logic signed [SAMPLE_BITS-1:0] in_sensor_q;
  logic signed [SAMPLE_BITS-1:0] in_target_q;

  // Controller state
  logic signed [SAMPLE_BITS-1:0] setpoint_q;
  logic signed [SAMPLE_BITS-1:0] start_value_q;
  logic signed [ERR_W-1:0]       last_error_q;
  logic signed [SUM_W-1:0]       error_sum_q;

  err_stage_t stage_q, stage_d;

  logic                    adv;
  logic                    in_ready;
  logic                    fire;
  logic                    is_start;
  logic signed [ERR_W-1:0] cur_ext;
  logic signed [ERR_W-1:0] sp_ext;
  logic signed [ERR_W-1:0] raw_err;
  logic signed [ERR_W-1:0] err;
  logic signed [DIFF_W-1:0] diff_raw;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [SUM_W-1:0] sum;
  logic                    ki_pos;
  logic [ERR_W-1:0]        mag;
  logic                    crossed;
  logic                    in_band;

  // Handshake: the stage moves when its output slot is free or being emptied
  assign adv         = !stage_q.valid || ready_i;
  assign in_ready    = !in_valid_q || adv;
  assign in_ch.ready = in_ready;
  assign fire        = in_valid_q && adv;
  assign is_start    = (in_op_q == OP_START);

  // Clamped error, clamped difference and saturating sum (clamped when integ_gain > 0)
  always_comb begin
    cur_ext  = ERR_W'(in_sensor_q);
    sp_ext   = ERR_W'(setpoint_q);
    raw_err  = sp_ext - cur_ext;
    err      = ERR_W'(clamp_abs(CLAMP_W'(raw_err), LIM_W'(cfg_i.error_limit)));

    diff_raw = DIFF_W'(err) - DIFF_W'(last_error_q);
    diff     = '0;
    if (last_error_q != '0) begin
      diff = DIFF_W'(clamp_abs(CLAMP_W'(diff_raw), LIM_W'(cfg_i.diff_limit)));
    end

    sum_wide = (SUM_W + 1)'(error_sum_q) + (SUM_W + 1)'(err);
    sum_sat  = sum_wide[SUM_W-1:0];
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    ki_pos = (cfg_i.integ_gain > 0);
    sum    = sum_sat;
    if (ki_pos) begin
      sum = SUM_W'(clamp_abs(CLAMP_W'(sum_sat), LIM_W'(cfg_i.integral_limit)));
    end

    // Done: setpoint crossed either way, or error inside the band
    crossed = ((start_value_q <= setpoint_q) && (in_sensor_q >= setpoint_q)) ||
              ((start_value_q >= setpoint_q) && (in_sensor_q <= setpoint_q));
    mag     = (raw_err < 0) ? unsigned'(-raw_err) : unsigned'(raw_err);
    in_band = (cfg_i.accuracy_band != '0) &&
              (MAG_W'(mag) <= MAG_W'(cfg_i.accuracy_band));

    stage_d       = stage_q;
    stage_d.valid = in_valid_q;
    if (in_valid_q) begin
      stage_d.start = is_start;
      stage_d.err   = err;
      stage_d.diff  = diff;
      stage_d.sum   = sum;
      stage_d.done  = !is_start && (crossed || in_band);
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_op_q     <= OP_UPDATE;
      in_sensor_q <= '0;
      in_target_q <= '0;
    end else if (in_ready) begin
      in_valid_q <= in_ch.valid;
      if (in_ch.valid) begin
        in_op_q     <= in_ch.operation;
        in_sensor_q <= in_ch.sensor_value;
        in_target_q <= in_ch.target_value;
      end
    end
  end

  // State update, once per item as it leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q    <= '0;
      start_value_q <= '0;
      last_error_q  <= '0;
      error_sum_q   <= '0;
    end else if (fire) begin
      if (is_start) begin
        setpoint_q    <= in_target_q;
        start_value_q <= in_sensor_q;
        last_error_q  <= '0;
        error_sum_q   <= '0;
      end else begin
        last_error_q <= err;
        error_sum_q  <= sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (adv) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/clpid_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_mult
// Product stage: P, I and D terms, each a registered 16-bit gain product.
// ----------------------------------------------------------------------------
module clpid_mult (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clpid_pkg::cfg_t        cfg_i,
  input  clpid_pkg::err_stage_t  stage_i,
  input  logic                   ready_i,
  output logic                   ready_o,
  output clpid_pkg::prod_stage_t stage_o
);
  import clpid_pkg::*;

  prod_stage_t stage_q, stage_d;

  assign ready_o = !stage_q.valid || ready_i;

  // Signed products of gain and path value
  always_comb begin
    stage_d       = stage_q;
    stage_d.valid = stage_i.valid;
    if (stage_i.valid) begin
      stage_d.start  = stage_i.start;
      stage_d.p_term = P_W'(cfg_i.prop_gain) * P_W'(stage_i.err);
      stage_d.i_term = I_W'(cfg_i.integ_gain) * I_W'(stage_i.sum);
      stage_d.d_term = D_W'(cfg_i.deriv_gain) * D_W'(stage_i.diff);
      stage_d.done   = stage_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

### sv/clpid_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_out
// Term sum, floor scaling, output clamp and saturation; result register.
// ----------------------------------------------------------------------------
module clpid_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clpid_pkg::cfg_t        cfg_i,
  input  clpid_pkg::prod_stage_t stage_i,
  output logic                   ready_o,
  clpid_out_if.source            out_ch
);
  import clpid_pkg::*;

  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      done_q, done_d;

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   scaled;
  logic signed [CLAMP_W-1:0] limited;

  assign ready_o = !out_valid_q || out_ch.ready;

  // Sum of terms, floor shift, output_limit clamp, then 16-bit saturation
  always_comb begin
    acc     = ACC_W'(stage_i.p_term) + ACC_W'(stage_i.i_term) + ACC_W'(stage_i.d_term);
    scaled  = acc >>> GAIN_FRAC_BITS;
    limited = clamp_abs(CLAMP_W'(scaled), LIM_W'(cfg_i.output_limit));
    if (limited > CLAMP_W'(DRIVE_MAX)) begin
      drive_d = DRIVE_W'(DRIVE_MAX);
    end else if (limited < CLAMP_W'(DRIVE_MIN)) begin
      drive_d = DRIVE_W'(DRIVE_MIN);
    end else begin
      drive_d = DRIVE_W'(limited);
    end
    done_d = stage_i.done;
    if (stage_i.start) begin
      drive_d = '0;
      done_d  = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      done_q      <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= stage_i.valid;
      if (stage_i.valid) begin
        drive_q <= drive_d;
        done_q  <= done_d;
      end
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.drive    = drive_q;
  assign out_ch.done_res = done_q;

endmodule

### sv/clamped_pid_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clamped_pid_controller
// PID controller with clamped error, difference, integral and drive.
//
// Usage:
//   in_ch  carries items: operation (start or update), sensor_value and
//          target_value. A start item latches setpoint and start value and
//          clears last error and error sum; its result is drive 0, done 0.
//   out_ch returns one item per input item, in order: drive and done_res.
//   The APB port holds gains and limits; write it only while idle.
// Timing:
//   Four registers in line (input, error stage, product stage, result); an
//   accepted item passes through them in that order. One item per cycle is
//   sustained while out_ch.ready stays high; the error stage closes the loop
//   on last error and error sum as each item leaves the input register.
// Reset:
//   rst_ni clears all registers, state and every pipeline valid bit.
// Stall:
//   A held result stays stable; earlier stages keep filling bubbles, and
//   in_ch.ready falls only once every stage holds an item.
// ----------------------------------------------------------------------------
module clamped_pid_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clpid_pkg::APB_AW-1:0] paddr,
  input  logic [clpid_pkg::APB_DW-1:0] pwdata,
  output logic [clpid_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  clpid_in_if.sink                     in_ch,
  clpid_out_if.source                  out_ch
);
  import clpid_pkg::*;

  cfg_t        cfg;
  err_stage_t  err_stage;
  prod_stage_t prod_stage;
  logic        mult_ready;
  logic        out_ready;

  clpid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clpid_err_path u_err_path (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .cfg_i   (cfg),
    .ready_i (mult_ready),
    .stage_o (err_stage)
  );

  clpid_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .stage_i (err_stage),
    .ready_i (out_ready),
    .ready_o (mult_ready),
    .stage_o (prod_stage)
  );

  clpid_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .stage_i (prod_stage),
    .ready_o (out_ready),
    .out_ch  (out_ch)
  );

endmodule

### sv/clpid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpid_checker
// Port-level checks on the clamped PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module clpid_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_operation,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [clpid_pkg::DRIVE_W-1:0] out_drive,
  input logic                              out_done,
  input logic                              pready
);
  import clpid_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // In reset nothing is offered and the input side is open
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> (!out_valid && in_ready))
    else $error("result offered or input blocked during reset");

  // Register port never inserts wait states
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  // With no stall, an accepted start item comes out as drive 0, done 0
  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_operation == OP_START)) ##1 out_ready ##1 out_ready ##1 out_ready
    |=> (out_valid && (out_drive == '0) && !out_done))
    else $error("start item result missing or not zero");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_drive) && $stable(out_done)))
    else $error("stalled result changed");

endmodule

bind clamped_pid_controller clpid_checker u_clpid_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_operation (in_ch.operation),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_drive    (out_ch.drive),
  .out_done     (out_ch.done_res),
  .pready       (pready)
);
